// ----- rtl/core/ops_pkg.sv -----
// ----------------------------------------------------------------------------
// ops_pkg
// Shared types and codes for the odd prime sieve engine and its checker.
// ----------------------------------------------------------------------------
package ops_pkg;

   localparam int CMD_W   = 1;
   localparam int VALUE_W = 13;

   // command codes
   localparam logic [CMD_W-1:0] CMD_BUILD = 1'b0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

   // status codes
   localparam logic STS_OK    = 1'b0;
   localparam logic STS_RANGE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLR,
      ST_MARK,
      ST_CR_RD,
      ST_CR_CHK,
      ST_CR_WR,
      ST_FIN
   } ops_state_type;

endpackage

// ----- rtl/core/ops_ram.sv -----
// ----------------------------------------------------------------------------
// ops_ram
// Single-port synchronous RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module ops_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/odd_prime_sieve_engine.sv -----
// ----------------------------------------------------------------------------
// odd_prime_sieve_engine
// Builds a primality table of odd numbers 2j+1 with a Sundaram sieve, then
// answers queries by odd index from that table.
// ----------------------------------------------------------------------------
// Query: result in the cycle after acceptance, one query per cycle, busy stays low.
// Build: clears the tables, marks the Sundaram rows, reads back each base index,
//   writes the cross-outs of each base prime into the odd table, then closes,
//   over entries 0..n, n = min((limit-1)/2, depth-1); each single-port table allows one access a cycle.
// The build result appears in the last busy cycle.
// Reset: synchronous; returns to idle with nothing built, tables not cleared.
module odd_prime_sieve_engine #(
   parameter int RESULT_DEPTH = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ops_pkg::CMD_W-1:0]   req_cmd,
   input  logic [ops_pkg::VALUE_W-1:0] req_value,
   output logic                        rsp_valid,
   output logic                        rsp_is_prime,
   output logic                        rsp_status
);

   import ops_pkg::*;

   localparam int IW = $clog2(RESULT_DEPTH);
   localparam int BASE_DEPTH = RESULT_DEPTH / 2;
   localparam int BW = $clog2(BASE_DEPTH);
   localparam int CW = ((IW > VALUE_W) ? IW : VALUE_W) + 2;
   localparam logic [CW-1:0] TOP_IDX = CW'(RESULT_DEPTH - 1);
   localparam logic [CW-1:0] ONE  = CW'(1);
   localparam logic [CW-1:0] TWO  = CW'(2);
   localparam logic [CW-1:0] FOUR = CW'(4);
   localparam logic [CW-1:0] FIRST_P = CW'(3);

   ops_state_type state_ff, state_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] s_ff, s_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] p_ff, p_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] maxi_ff, maxi_in;
   logic [VALUE_W-1:0] top_ff, top_in;
   logic valid_ff, valid_in;
   logic qpend_ff, qpend_in;
   logic qoor_ff, qoor_in;

   logic accept;
   logic [CW-1:0] lim_ext, half, n_calc, s_next;
   logic build_done;

   logic          base_we, base_wdata, base_rdata;
   logic [BW-1:0] base_addr;
   logic          odd_we, odd_wdata, odd_rdata;
   logic [IW-1:0] odd_addr;

   ops_ram #(.WIDTH(1), .DEPTH(BASE_DEPTH)) u_base_ram (
      .clock (clock),
      .we    (base_we),
      .addr  (base_addr),
      .wdata (base_wdata),
      .rdata (base_rdata)
   );

   ops_ram #(.WIDTH(1), .DEPTH(RESULT_DEPTH)) u_odd_ram (
      .clock (clock),
      .we    (odd_we),
      .addr  (odd_addr),
      .wdata (odd_wdata),
      .rdata (odd_rdata)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         top_ff   <= '0;
         valid_ff <= 1'b0;
         qpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         valid_ff <= valid_in;
         qpend_ff <= qpend_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      s_ff    <= s_in;
      k_ff    <= k_in;
      p_ff    <= p_in;
      n_ff    <= n_in;
      maxi_ff <= maxi_in;
      qoor_ff <= qoor_in;
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      s_in     = s_ff;
      k_in     = k_ff;
      p_in     = p_ff;
      n_in     = n_ff;
      maxi_in  = maxi_ff;
      top_in   = top_ff;
      valid_in = valid_ff;
      qpend_in = 1'b0;
      qoor_in  = qoor_ff;

      base_we    = 1'b0;
      base_addr  = k_ff[BW-1:0];
      base_wdata = 1'b0;
      odd_we     = 1'b0;
      odd_addr   = k_ff[IW-1:0];
      odd_wdata  = 1'b0;
      build_done = 1'b0;

      lim_ext = CW'(req_value);
      half    = (lim_ext == '0) ? '0 : ((lim_ext - ONE) >> 1);
      n_calc  = (half > TOP_IDX) ? TOP_IDX : half;
      // next base index start 2i(i+1) grows by 4(i+1)
      s_next  = s_ff + {i_ff[CW-3:0], 2'b00} + FOUR;

      case (state_ff)
         ST_IDLE: begin
            odd_addr = lim_ext[IW-1:0];
            if (accept) begin
               if (req_cmd == CMD_QUERY) begin
                  qpend_in = 1'b1;
                  qoor_in  = !valid_ff || (req_value > top_ff);
               end else begin
                  n_in     = n_calc;
                  maxi_in  = (n_calc >= ONE) ? ((n_calc - ONE) >> 1) : '0;
                  k_in     = '0;
                  state_in = ST_CLR;
               end
            end
         end
         ST_CLR: begin
            // entry 0 (the number 1) is written as not prime
            odd_we    = 1'b1;
            odd_wdata = (k_ff != '0);
            base_we   = (k_ff <= maxi_ff);
            if (k_ff == n_ff) begin
               i_in     = ONE;
               s_in     = FOUR;
               k_in     = FOUR;
               p_in     = FIRST_P;
               state_in = ST_MARK;
            end else begin
               k_in = k_ff + ONE;
            end
         end
         ST_MARK: begin
            if (k_ff <= maxi_ff) begin
               base_we    = 1'b1;
               base_wdata = 1'b1;
               k_in       = k_ff + p_ff;
            end else if (s_next > maxi_ff) begin
               i_in     = ONE;
               s_in     = FOUR;
               p_in     = FIRST_P;
               state_in = ST_CR_RD;
            end else begin
               i_in = i_ff + ONE;
               s_in = s_next;
               k_in = s_next;
               p_in = p_ff + TWO;
            end
         end
         ST_CR_RD: begin
            base_addr = i_ff[BW-1:0];
            if (s_ff > n_ff) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_CR_CHK;
            end
         end
         ST_CR_CHK: begin
            if (!base_rdata) begin
               k_in     = s_ff;
               state_in = ST_CR_WR;
            end else begin
               i_in     = i_ff + ONE;
               s_in     = s_next;
               p_in     = p_ff + TWO;
               state_in = ST_CR_RD;
            end
         end
         ST_CR_WR: begin
            if (k_ff <= n_ff) begin
               odd_we = 1'b1;
               k_in   = k_ff + p_ff;
            end else begin
               i_in     = i_ff + ONE;
               s_in     = s_next;
               p_in     = p_ff + TWO;
               state_in = ST_CR_RD;
            end
         end
         ST_FIN: begin
            build_done = 1'b1;
            top_in     = n_ff[VALUE_W-1:0];
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = qpend_ff || build_done;
   assign rsp_is_prime = qpend_ff && !qoor_ff && odd_rdata;
   assign rsp_status   = (qpend_ff && qoor_ff) ? STS_RANGE : STS_OK;

endmodule

// ----- rtl/core/ops_checker.sv -----
// ----------------------------------------------------------------------------
// ops_checker
// Port-level checks for the odd prime sieve engine, bound to the top level.
// ----------------------------------------------------------------------------
module ops_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [ops_pkg::CMD_W-1:0] req_cmd,
   input logic                      rsp_valid,
   input logic                      rsp_is_prime,
   input logic                      rsp_status
);

   import ops_pkg::*;

   // a query transaction is answered in the next cycle
   a_query_next: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_QUERY) |=> rsp_valid)
      else $error("query transaction not answered in the next cycle");

   a_build_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_BUILD) |=> busy)
      else $error("build transaction did not raise busy");

   // a build ends with its ok result in the last busy cycle
   a_build_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |->
         $past(rsp_valid && (rsp_status == STS_OK) && !rsp_is_prime))
      else $error("build finished without its result");

   a_idle_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy && !$past(reset) |->
         $past(start && !busy && (req_cmd == CMD_QUERY)))
      else $error("result while idle without a query transaction");

   a_range_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_RANGE) |-> !rsp_is_prime)
      else $error("out-of-range result flagged prime");

endmodule

bind odd_prime_sieve_engine ops_checker u_ops_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_cmd      (req_cmd),
   .rsp_valid    (rsp_valid),
   .rsp_is_prime (rsp_is_prime),
   .rsp_status   (rsp_status)
);
